// ===== rtl/scfl_pkg.sv =====
package scfl_pkg;

  // field widths
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned SIZE_W   = 32;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CLS_W    = 7;
  localparam int unsigned PAD_W    = 21;

  // arena and class geometry
  localparam int unsigned ARENA_BYTES   = 65536;
  localparam int unsigned LARGE_LIMIT   = 4096;
  localparam int unsigned CLASS_COUNT   = 128;
  localparam int unsigned GRAN_BYTES    = 8;
  localparam int unsigned GRAN_SH       = $clog2(GRAN_BYTES);
  localparam int unsigned GRANULES      = ARENA_BYTES / GRAN_BYTES;
  localparam int unsigned GRAN_W        = $clog2(GRANULES);
  localparam int unsigned HEAD_W        = GRAN_W + 1;
  localparam int unsigned ARENA_AW      = $clog2(ARENA_BYTES);
  localparam int unsigned BUMP_W        = ARENA_AW + 1;
  localparam int unsigned WASTE_W       = $clog2(LARGE_LIMIT) + 1;
  localparam int unsigned CLS_IDX_W     = $clog2(CLASS_COUNT);
  localparam int unsigned SMALL_MAX     = 512;
  localparam int unsigned SMALL_W       = $clog2(SMALL_MAX) + 1;
  localparam int unsigned POW_CLASS_OFS = 55;

  // front to back queue
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned Q_PTR_W     = $clog2(QUEUE_DEPTH);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_LARGE     = 3'd1,
    ST_EXHAUSTED = 3'd2,
    ST_NULL_FREE = 3'd3,
    ST_FOREIGN   = 3'd4
  } status_t;

  // classified request, as handed from front to back
  typedef struct packed {
    opcode_t               op;
    logic                  is_large;
    logic                  is_null;
    logic                  is_foreign;
    logic [CLS_W-1:0]      cls;
    logic [PAD_W-1:0]      padded;
    logic [WASTE_W-1:0]    waste;
    logic [GRAN_W-1:0]     granule;
    logic [SIZE_W-1:0]     req_size;
  } scfl_op_t;

endpackage

// ===== rtl/scfl_if.sv =====
interface scfl_req_if import scfl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [SIZE_W-1:0]   req_size;
  logic [ADDR_W-1:0]   block_address;

  modport source (output valid, opcode, req_size, block_address, input ready);
  modport sink   (input valid, opcode, req_size, block_address, output ready);
endinterface

interface scfl_rsp_if import scfl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   address;
  logic [STATUS_W-1:0] status;
  logic [CLS_W-1:0]    size_class;
  logic [PAD_W-1:0]    rounded_size;
  logic [CNT_W-1:0]    bytes_allocated;
  logic [CNT_W-1:0]    bytes_unused;
  logic [CNT_W-1:0]    bytes_wasted;

  modport source (output valid, address, status, size_class, rounded_size,
                  bytes_allocated, bytes_unused, bytes_wasted, input ready);
  modport sink   (input valid, address, status, size_class, rounded_size,
                  bytes_allocated, bytes_unused, bytes_wasted, output ready);
endinterface

// ===== rtl/scfl_front.sv =====
module scfl_front import scfl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [ADDR_W-1:0] arena_base,
  scfl_req_if.sink          in_req,
  output logic              push_valid,
  output scfl_op_t          push_data,
  input  logic              push_ready
);

  // highest set bit of a byte
  function automatic logic [2:0] msb8(input logic [7:0] v);
    logic [2:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) r = 3'(i);
    end
    return r;
  endfunction

  logic                  s1_valid_r;
  opcode_t               s1_op_r;
  logic [SIZE_W-1:0]     s1_size_r;
  logic                  s1_null_r;
  logic                  s1_foreign_r;
  logic [GRAN_W-1:0]     s1_gran_r;
  logic [3:0]            s1_nz_r;
  logic [3:0][2:0]       s1_bmsb_r;

  logic                  accept;
  logic [ADDR_W-1:0]     off;
  logic [SIZE_W-1:0]     dm;

  logic                  is_small;
  logic [SMALL_W-1:0]    eff_small;
  logic [SMALL_W-1:0]    eff_m1;
  logic [CLS_W-1:0]      cls_small;
  logic [4:0]            msb;
  logic [CLS_W-1:0]      cls;
  logic [PAD_W-1:0]      padded;
  logic [WASTE_W-1:0]    eff_w;

  assign in_req.ready = !s1_valid_r || push_ready;
  assign accept       = in_req.valid && in_req.ready;
  assign off          = in_req.block_address - arena_base;
  assign dm           = in_req.req_size - SIZE_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_req.ready) begin
      s1_valid_r <= in_req.valid;
    end
  end

  // size - 1 is split into bytes here so the ceil log2 finishes after the register
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r      <= opcode_t'(in_req.opcode);
      s1_size_r    <= in_req.req_size;
      s1_null_r    <= (in_req.block_address == '0);
      s1_foreign_r <= (off >= ADDR_W'(ARENA_BYTES));
      s1_gran_r    <= off[ARENA_AW-1:GRAN_SH];
      for (int b = 0; b < 4; b++) begin
        s1_nz_r[b]   <= (dm[b*8 +: 8] != 8'd0);
        s1_bmsb_r[b] <= msb8(dm[b*8 +: 8]);
      end
    end
  end

  always_comb begin
    is_small  = (s1_size_r <= SIZE_W'(SMALL_MAX));
    eff_small = (s1_size_r == '0) ? SMALL_W'(GRAN_BYTES) : s1_size_r[SMALL_W-1:0];
    eff_m1    = eff_small - SMALL_W'(1);
    cls_small = CLS_W'(eff_m1 >> GRAN_SH);

    priority if (s1_nz_r[3]) msb = {2'd3, s1_bmsb_r[3]};
    else if (s1_nz_r[2])     msb = {2'd2, s1_bmsb_r[2]};
    else if (s1_nz_r[1])     msb = {2'd1, s1_bmsb_r[1]};
    else                     msb = {2'd0, s1_bmsb_r[0]};

    if (is_small) begin
      cls    = cls_small;
      padded = (PAD_W'(cls_small) + PAD_W'(1)) << GRAN_SH;
    end else begin
      // ceil log2 of size is msb(size - 1) + 1
      cls    = CLS_W'(msb) + CLS_W'(POW_CLASS_OFS + 1);
      padded = (msb < 5'(PAD_W - 1)) ? (PAD_W'(1) << (6'(msb) + 6'd1)) : '0;
    end

    eff_w = (s1_size_r == '0) ? WASTE_W'(GRAN_BYTES) : s1_size_r[WASTE_W-1:0];
  end

  assign push_valid           = s1_valid_r;
  assign push_data.op         = s1_op_r;
  assign push_data.is_large   = (s1_size_r >= SIZE_W'(LARGE_LIMIT));
  assign push_data.is_null    = s1_null_r;
  assign push_data.is_foreign = s1_foreign_r;
  assign push_data.cls        = cls;
  assign push_data.padded     = padded;
  assign push_data.waste      = padded[WASTE_W-1:0] - eff_w;
  assign push_data.granule    = s1_gran_r;
  assign push_data.req_size   = s1_size_r;

endmodule

// ===== rtl/scfl_queue.sv =====
module scfl_queue import scfl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  input  scfl_op_t push_data,
  output logic     push_ready,
  output logic     pop_valid,
  output scfl_op_t pop_data,
  input  logic     pop
);

  scfl_op_t             slot_r [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r;
  logic [Q_PTR_W-1:0]   rd_ptr_r;
  logic [Q_PTR_W:0]     count_r;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = (count_r != (Q_PTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + (Q_PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (Q_PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/scfl_back.sv =====
module scfl_back import scfl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [ADDR_W-1:0] arena_base,
  input  logic              q_valid,
  input  scfl_op_t          q_data,
  output logic              q_pop,
  scfl_rsp_if.source        out_rsp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_POP
  } state_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_ADD,
    CNT_SUB
  } cnt_op_t;

  function automatic logic [CNT_W-1:0] sat_upd(input logic [CNT_W-1:0] c,
                                               input cnt_op_t op,
                                               input logic [CNT_W-1:0] amt);
    logic [CNT_W:0] s;
    s = {1'b0, c} + {1'b0, amt};
    unique case (op)
      CNT_ADD: return s[CNT_W] ? '1 : s[CNT_W-1:0];
      CNT_SUB: return (amt >= c) ? '0 : c - amt;
      default: return c;
    endcase
  endfunction

  state_t               state_r, state_nxt;
  scfl_op_t             cur_r;
  logic [GRAN_W-1:0]    g_r;
  logic [BUMP_W-1:0]    bump_r, bump_nxt;
  logic [CNT_W-1:0]     alloc_cnt_r, alloc_cnt_nxt;
  logic [CNT_W-1:0]     unused_cnt_r, unused_cnt_nxt;
  logic [CNT_W-1:0]     wasted_cnt_r, wasted_cnt_nxt;

  logic                 out_valid_r;
  logic [ADDR_W-1:0]    out_addr_r;
  status_t              out_status_r;
  logic [CLS_W-1:0]     out_cls_r;
  logic [PAD_W-1:0]     out_pad_r;

  // free list heads with per-class valid bits, links without
  logic [HEAD_W-1:0]    head_mem [CLASS_COUNT];
  logic [CLASS_COUNT-1:0] head_vld_r;
  logic [HEAD_W-1:0]    head_rd_r;
  logic                 head_rd_vld_r;
  logic [HEAD_W-1:0]    link_mem [GRANULES];
  logic [HEAD_W-1:0]    link_rd_r;

  logic [HEAD_W-1:0]    head_eff;
  logic [GRAN_W-1:0]    g_pop;
  logic [ADDR_W:0]      bump_sum;
  logic                 emit, emit_ok, commit, pop_path;
  status_t              st_o;
  logic [ADDR_W-1:0]    addr_o;
  logic [PAD_W-1:0]     pad_o;
  logic                 head_we, link_we, link_re;
  logic [HEAD_W-1:0]    head_wd;
  logic                 bump_we;
  cnt_op_t              alloc_op, unused_op, waste_op;
  logic [CNT_W-1:0]     alloc_amt, unused_amt, waste_amt;

  assign q_pop    = (state_r == S_IDLE) && q_valid;
  assign head_eff = head_rd_vld_r ? head_rd_r : '0;
  assign g_pop    = GRAN_W'(head_eff - HEAD_W'(1));
  assign bump_sum = (ADDR_W+1)'(bump_r) + (ADDR_W+1)'(cur_r.padded);
  assign emit_ok  = !out_valid_r || out_rsp.ready;
  assign commit   = emit && emit_ok;

  always_comb begin
    emit      = 1'b0;
    pop_path  = 1'b0;
    st_o      = ST_OK;
    addr_o    = '0;
    pad_o     = cur_r.padded;
    head_we   = 1'b0;
    head_wd   = HEAD_W'(cur_r.granule) + HEAD_W'(1);
    link_we   = 1'b0;
    link_re   = 1'b0;
    bump_we   = 1'b0;
    alloc_op  = CNT_HOLD;
    unused_op = CNT_HOLD;
    waste_op  = CNT_HOLD;
    alloc_amt  = CNT_W'(cur_r.padded);
    unused_amt = CNT_W'(cur_r.padded);
    waste_amt  = CNT_W'(cur_r.waste);
    state_nxt = state_r;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (cur_r.op == OP_ALLOC) begin
          priority if (cur_r.is_large) begin
            emit      = 1'b1;
            st_o      = ST_LARGE;
            pad_o     = '0;
            alloc_op  = CNT_ADD;
            alloc_amt = cur_r.req_size;
          end else if (head_eff != '0) begin
            pop_path = 1'b1;
            link_re  = 1'b1;
          end else if (bump_sum > (ADDR_W+1)'(ARENA_BYTES)) begin
            emit = 1'b1;
            st_o = ST_EXHAUSTED;
          end else begin
            emit     = 1'b1;
            addr_o   = arena_base + ADDR_W'(bump_r);
            bump_we  = 1'b1;
            waste_op = CNT_ADD;
            alloc_op = CNT_ADD;
          end
        end else begin
          priority if (cur_r.is_null) begin
            emit = 1'b1;
            st_o = ST_NULL_FREE;
          end else if (cur_r.is_large) begin
            emit      = 1'b1;
            st_o      = ST_LARGE;
            pad_o     = '0;
            alloc_op  = CNT_SUB;
            alloc_amt = cur_r.req_size;
          end else if (cur_r.is_foreign) begin
            emit = 1'b1;
            st_o = ST_FOREIGN;
          end else begin
            // push: old head becomes this granule's link
            emit      = 1'b1;
            link_we   = commit;
            head_we   = commit;
            unused_op = CNT_ADD;
            waste_op  = CNT_SUB;
            alloc_op  = CNT_SUB;
          end
        end
        if (pop_path) state_nxt = S_POP;
        else if (commit) state_nxt = S_IDLE;
      end
      S_POP: begin
        emit      = 1'b1;
        addr_o    = arena_base + (ADDR_W'(g_r) << GRAN_SH);
        head_we   = commit;
        head_wd   = link_rd_r;
        unused_op = CNT_SUB;
        waste_op  = CNT_ADD;
        alloc_op  = CNT_ADD;
        if (commit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    bump_nxt       = bump_we ? BUMP_W'(bump_sum) : bump_r;
    alloc_cnt_nxt  = sat_upd(alloc_cnt_r, alloc_op, alloc_amt);
    unused_cnt_nxt = sat_upd(unused_cnt_r, unused_op, unused_amt);
    wasted_cnt_nxt = sat_upd(wasted_cnt_r, waste_op, waste_amt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      bump_r       <= '0;
      alloc_cnt_r  <= '0;
      unused_cnt_r <= '0;
      wasted_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (q_pop) cur_r <= q_data;
      if (pop_path) g_r <= g_pop;
      if (commit) begin
        out_valid_r  <= 1'b1;
        out_addr_r   <= addr_o;
        out_status_r <= st_o;
        out_cls_r    <= cur_r.cls;
        out_pad_r    <= pad_o;
        bump_r       <= bump_nxt;
        alloc_cnt_r  <= alloc_cnt_nxt;
        unused_cnt_r <= unused_cnt_nxt;
        wasted_cnt_r <= wasted_cnt_nxt;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      head_rd_r     <= head_mem[q_data.cls[CLS_IDX_W-1:0]];
      head_rd_vld_r <= head_vld_r[q_data.cls[CLS_IDX_W-1:0]];
    end
    if (head_we) begin
      head_mem[cur_r.cls[CLS_IDX_W-1:0]] <= head_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= '0;
    end else if (head_we) begin
      head_vld_r[cur_r.cls[CLS_IDX_W-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[cur_r.granule] <= head_eff;
    end
    if (link_re) begin
      link_rd_r <= link_mem[g_pop];
    end
  end

  assign out_rsp.valid           = out_valid_r;
  assign out_rsp.address         = out_addr_r;
  assign out_rsp.status          = out_status_r;
  assign out_rsp.size_class      = out_cls_r;
  assign out_rsp.rounded_size    = out_pad_r;
  assign out_rsp.bytes_allocated = alloc_cnt_r;
  assign out_rsp.bytes_unused    = unused_cnt_r;
  assign out_rsp.bytes_wasted    = wasted_cnt_r;

endmodule

// ===== rtl/size_class_free_list_allocator.sv =====
// channel   dir  handshake          payload
// in_req    in   valid/ready        opcode, req_size, block_address
// out_rsp   out  valid/ready        address, status, size_class, rounded_size, byte counters
// cfg       in   cfg_we, no wait    cfg_wdata -> arena_base
//
// front stage: registers and classifies each request, then a two-entry queue
// back: one item at a time, idle (head read) then decide, plus a pop state when an alloc pops a
//   class list, for the dependent read of the link memory for the new head
// reset: synchronous, class heads come up empty through per-class valid bits,
//   no clearing pass; link memory is not cleared
// stalls: a held result only stops the back; the front keeps filling the queue until it is full
module size_class_free_list_allocator import scfl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  scfl_req_if.sink          in_req,
  scfl_rsp_if.source        out_rsp,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_wdata
);

  logic [ADDR_W-1:0] arena_base_r;

  // front to queue
  logic              push_valid;
  scfl_op_t          push_data;
  logic              push_ready;

  // queue to back
  logic              q_valid;
  scfl_op_t          q_data;
  logic              q_pop;

  // arena base; the user must write it only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arena_base_r <= '0;
    end else if (cfg_we) begin
      arena_base_r <= cfg_wdata;
    end
  end

  // classify size, null/foreign check, granule index
  scfl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .arena_base (arena_base_r),
    .in_req     (in_req),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  // decouples front from back
  scfl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_data   (q_data),
    .pop        (q_pop)
  );

  // free lists, bump pointer, counters, result register
  scfl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .arena_base (arena_base_r),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_rsp    (out_rsp)
  );

  // any failed or large request hands back no address
  a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_rsp.valid && out_rsp.status != ST_OK) |-> (out_rsp.address == '0))
    else $error("nonzero address on a request that did not allocate");

  // large requests report no rounded size
  a_large_no_pad: assert property (@(posedge clk) disable iff (!rst_n)
    (out_rsp.valid && out_rsp.status == ST_LARGE) |-> (out_rsp.rounded_size == '0))
    else $error("large request with rounded size");

  // exhaustion only happens for a real nonzero block size
  a_exh_pad: assert property (@(posedge clk) disable iff (!rst_n)
    (out_rsp.valid && out_rsp.status == ST_EXHAUSTED) |-> (out_rsp.rounded_size != '0))
    else $error("arena exhausted on zero rounded size");

  // back only pops when the queue holds an item
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  import scfl_pkg::*;

  // one predicted or observed result item
  typedef struct {
    logic [ADDR_W-1:0] address;
    status_t           status;
    logic [CLS_W-1:0]  size_class;
    logic [PAD_W-1:0]  rounded_size;
    logic [CNT_W-1:0]  bytes_allocated;
    logic [CNT_W-1:0]  bytes_unused;
    logic [CNT_W-1:0]  bytes_wasted;
  } alloc_result_t;

  // a block handed out by the allocator, kept so that it can be freed later
  typedef struct {
    logic [ADDR_W-1:0] ofs;
    logic [SIZE_W-1:0] size;
  } live_block_t;

  // cycles with no item moving on either channel before the run is called hung
  localparam int unsigned STALL_LIMIT = 2000;
  // result count at which the receiver holds off, and for how long
  localparam int unsigned HOLD_AT     = 300;
  localparam int unsigned HOLD_CYCLES = 80;
  // settle time after the last result, covers front stage, queue and back
  localparam int unsigned SETTLE      = 8;

  // allocator model plus the ordered list of results still to come
  class alloc_checker;
    logic [ADDR_W-1:0] arena_base;
    logic [HEAD_W-1:0] class_head [CLASS_COUNT];
    logic [HEAD_W-1:0] next_link [GRANULES];
    logic [BUMP_W-1:0] bump_ofs;
    logic [CNT_W-1:0]  alloc_bytes;
    logic [CNT_W-1:0]  unused_bytes;
    logic [CNT_W-1:0]  wasted_bytes;
    alloc_result_t     awaited[$];
    int unsigned       errors;
    int unsigned       matched;
    int unsigned       pops;
    int unsigned       status_seen [5];

    function new();
      arena_base   = '0;
      bump_ofs     = '0;
      alloc_bytes  = '0;
      unused_bytes = '0;
      wasted_bytes = '0;
      errors       = 0;
      matched      = 0;
      pops         = 0;
      foreach (class_head[i]) class_head[i] = '0;
      foreach (next_link[i]) next_link[i] = '0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function logic [CNT_W-1:0] sat_up(logic [CNT_W-1:0] a, longint unsigned b);
      longint unsigned s;
      s = longint'(a) + b;
      return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(s);
    endfunction

    function logic [CNT_W-1:0] sat_down(logic [CNT_W-1:0] a, longint unsigned b);
      return (b >= longint'(a)) ? '0 : 32'(longint'(a) - b);
    endfunction

    function int unsigned ceil_log2(logic [SIZE_W-1:0] v);
      int unsigned k;
      k = 0;
      while (k < 40 && (64'd1 << k) < {32'd0, v}) k++;
      return k;
    endfunction

    // advance the model by one accepted request and queue what it must return
    function alloc_result_t predict_request(opcode_t op, logic [SIZE_W-1:0] size,
                                            logic [ADDR_W-1:0] blk_addr);
      alloc_result_t     r;
      int unsigned       eff, cls, padded, waste, k, g;
      logic [ADDR_W-1:0] ofs;
      logic [HEAD_W-1:0] head;

      eff = (size == 0) ? 8 : size;
      if (size <= SMALL_MAX) begin
        cls    = (eff + 7) / 8 - 1;
        padded = (cls + 1) * 8;
      end else begin
        k      = ceil_log2(size);
        cls    = k + POW_CLASS_OFS;
        padded = (k < 21) ? (1 << k) : 0;
      end
      cls   = cls % CLASS_COUNT;
      waste = padded - eff;

      r.address = '0;
      r.status  = ST_OK;
      if (op == OP_ALLOC) begin
        if (size >= LARGE_LIMIT) begin
          alloc_bytes = sat_up(alloc_bytes, size);
          r.status    = ST_LARGE;
          padded      = 0;
        end else begin
          head = class_head[cls];
          if (head != 0) begin
            g               = (head - 1) % GRANULES;
            class_head[cls] = next_link[g];
            r.address       = arena_base + (32'(g) << GRAN_SH);
            unused_bytes    = sat_down(unused_bytes, padded);
            wasted_bytes    = sat_up(wasted_bytes, waste);
            alloc_bytes     = sat_up(alloc_bytes, padded);
            pops++;
          end else if (longint'(bump_ofs) + padded > ARENA_BYTES) begin
            r.status = ST_EXHAUSTED;
          end else begin
            r.address    = arena_base + 32'(bump_ofs);
            bump_ofs     = bump_ofs + BUMP_W'(padded);
            wasted_bytes = sat_up(wasted_bytes, waste);
            alloc_bytes  = sat_up(alloc_bytes, padded);
          end
        end
      end else begin
        ofs = blk_addr - arena_base;
        if (blk_addr == 0) begin
          r.status = ST_NULL_FREE;
        end else if (size >= LARGE_LIMIT) begin
          alloc_bytes = sat_down(alloc_bytes, size);
          r.status    = ST_LARGE;
          padded      = 0;
        end else if (ofs >= ARENA_BYTES) begin
          r.status = ST_FOREIGN;
        end else begin
          g               = (ofs >> GRAN_SH) % GRANULES;
          next_link[g]    = class_head[cls];
          class_head[cls] = HEAD_W'(g + 1);
          unused_bytes    = sat_up(unused_bytes, padded);
          wasted_bytes    = sat_down(wasted_bytes, waste);
          alloc_bytes     = sat_down(alloc_bytes, padded);
        end
      end

      r.size_class      = CLS_W'(cls);
      r.rounded_size    = PAD_W'(padded);
      r.bytes_allocated = alloc_bytes;
      r.bytes_unused    = unused_bytes;
      r.bytes_wasted    = wasted_bytes;
      status_seen[r.status]++;
      awaited.push_back(r);
      return r;
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t want;
      if (awaited.size() == 0) begin
        $error("result with nothing outstanding: address %h status %0d",
               got.address, got.status);
        errors++;
        return;
      end
      want = awaited.pop_front();
      matched++;
      if (got.address !== want.address) begin
        $error("address: expected %h, got %h", want.address, got.address);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.size_class !== want.size_class) begin
        $error("size_class: expected %0d, got %0d", want.size_class, got.size_class);
        errors++;
      end
      if (got.rounded_size !== want.rounded_size) begin
        $error("rounded_size: expected %0d, got %0d", want.rounded_size, got.rounded_size);
        errors++;
      end
      if (got.bytes_allocated !== want.bytes_allocated) begin
        $error("bytes_allocated: expected %h, got %h",
               want.bytes_allocated, got.bytes_allocated);
        errors++;
      end
      if (got.bytes_unused !== want.bytes_unused) begin
        $error("bytes_unused: expected %h, got %h", want.bytes_unused, got.bytes_unused);
        errors++;
      end
      if (got.bytes_wasted !== want.bytes_wasted) begin
        $error("bytes_wasted: expected %h, got %h", want.bytes_wasted, got.bytes_wasted);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [ADDR_W-1:0] cfg_wdata;

  scfl_req_if req_ch ();
  scfl_rsp_if rsp_ch ();

  size_class_free_list_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_ch),
    .out_rsp   (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  alloc_checker sb = new();

  // blocks the model says are handed out, offsets relative to the arena
  live_block_t live_q[$];
  bit          send_calm;
  bit          rsp_calm;
  int unsigned results_taken;
  int unsigned alloc_sent;
  int unsigned free_sent;
  int unsigned bases_used;
  int unsigned quiet_cycles;

  // 12 unit period, high then low
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // everything the block reads has a known value from time zero
  initial begin
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    req_ch.valid         = 1'b0;
    req_ch.opcode        = OP_ALLOC;
    req_ch.req_size      = '0;
    req_ch.block_address = '0;
    rsp_ch.ready         = 1'b0;
  end

  // hang detector: any item moving on either channel restarts the count
  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: %0d results still awaited", sb.awaited.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stalls, calm stretches, and one long hold-off so the
  // two-entry queue fills and the block pushes back on its input
  initial begin : result_sink
    int unsigned   stall;
    alloc_result_t got;
    results_taken = 0;
    rsp_calm      = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (results_taken % 40 == 0) rsp_calm = ($urandom_range(0, 3) == 0);
      stall = rsp_calm ? 0 : $urandom_range(0, 4);
      if (results_taken == HOLD_AT) stall = HOLD_CYCLES;
      @(negedge clk);
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      got.address         = rsp_ch.address;
      got.status          = status_t'(rsp_ch.status);
      got.size_class      = rsp_ch.size_class;
      got.rounded_size    = rsp_ch.rounded_size;
      got.bytes_allocated = rsp_ch.bytes_allocated;
      got.bytes_unused    = rsp_ch.bytes_unused;
      got.bytes_wasted    = rsp_ch.bytes_wasted;
      sb.check_result(got);
      results_taken++;
    end
  end

  // offer one request, hold it until taken, then fold it into the model;
  // successful allocations join the live list for later frees
  task automatic send_request(opcode_t op, logic [SIZE_W-1:0] size,
                              logic [ADDR_W-1:0] blk_addr);
    alloc_result_t want;
    live_block_t   blk;
    int unsigned   gap;
    gap = send_calm ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.opcode        <= op;
    req_ch.req_size      <= size;
    req_ch.block_address <= blk_addr;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    want = sb.predict_request(op, size, blk_addr);
    if (op == OP_ALLOC) begin
      alloc_sent++;
      if (want.status == ST_OK) begin
        blk.ofs  = want.address - sb.arena_base;
        blk.size = size;
        live_q.push_back(blk);
      end
    end else begin
      free_sent++;
    end
  endtask

  // drop valid, wait out every awaited result, then let the pipe go quiet
  task automatic quiesce();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // the base register only changes while nothing is in flight
  task automatic set_arena_base(logic [ADDR_W-1:0] base);
    @(negedge clk);
    cfg_wdata <= base;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.arena_base = base;
    bases_used++;
  endtask

  // mostly small sizes; fill mode leans on the 4 KiB class to drain the arena
  function automatic logic [SIZE_W-1:0] pick_alloc_size(bit fill_arena);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (fill_arena && r < 60) return $urandom_range(2049, LARGE_LIMIT - 1);
    if (r < 55) return $urandom_range(0, SMALL_MAX);
    if (r < 70) return $urandom_range(0, 24);
    if (r < 85) return $urandom_range(SMALL_MAX + 1, LARGE_LIMIT - 1);
    if (r < 93) return $urandom_range(LARGE_LIMIT, 1 << 22);
    return $urandom();
  endfunction

  // random traffic: allocations, frees of live blocks with their own size,
  // and a share of junk (null, foreign, wild and large frees)
  task automatic random_traffic(int unsigned n, bit fill_arena);
    int unsigned       i, pick, idx;
    live_block_t       blk;
    logic [ADDR_W-1:0] addr;
    for (i = 0; i < n; i++) begin
      if (i % 40 == 0) send_calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 50 || (pick < 80 && live_q.size() == 0)) begin
        send_request(OP_ALLOC, pick_alloc_size(fill_arena), $urandom());
      end else if (pick < 80) begin
        idx  = $urandom_range(0, live_q.size() - 1);
        blk  = live_q[idx];
        live_q.delete(idx);
        addr = sb.arena_base + blk.ofs;
        // sometimes point inside the first granule rather than at its start
        if ($urandom_range(0, 4) == 0) addr = addr + $urandom_range(1, 7);
        send_request(OP_FREE, blk.size, addr);
      end else begin
        case ($urandom_range(0, 4))
          0: send_request(OP_FREE, $urandom_range(0, LARGE_LIMIT - 1), '0);
          1: send_request(OP_FREE, $urandom_range(0, LARGE_LIMIT - 1),
                          sb.arena_base + $urandom_range(ARENA_BYTES, 32'hFFFF_FFFF));
          2: send_request(OP_FREE, $urandom_range(0, LARGE_LIMIT - 1), $urandom());
          // double free or wrong size somewhere inside the arena
          3: send_request(OP_FREE, $urandom_range(0, LARGE_LIMIT - 1),
                          sb.arena_base + $urandom_range(0, ARENA_BYTES - 1));
          default: send_request(OP_FREE, $urandom_range(LARGE_LIMIT, 32'hFFFF_FFFF),
                                $urandom());
        endcase
      end
    end
  endtask

  initial begin : stimulus
    alloc_sent   = 0;
    free_sent    = 0;
    bases_used   = 0;
    quiet_cycles = 0;
    send_calm    = 1'b0;

    // synchronous reset, released on a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part, arena base still at its reset value of zero
    // free into empty counters, both waste and allocated floor at zero
    send_request(OP_FREE, 32'd9, 32'h0000_0018);
    // zero size counts as 8, then a 1 byte request shares class 0
    send_request(OP_ALLOC, 32'd0, 32'hFFFF_FFFF);
    send_request(OP_ALLOC, 32'd1, 32'h0);
    // class 1 pops the block pushed above
    send_request(OP_ALLOC, 32'd16, $urandom());
    // small, power of two and last sub-large boundaries
    send_request(OP_ALLOC, SMALL_MAX, $urandom());
    send_request(OP_ALLOC, SMALL_MAX + 1, $urandom());
    send_request(OP_ALLOC, LARGE_LIMIT - 1, $urandom());
    // large requests go to the system; the counter saturates at the top
    send_request(OP_ALLOC, LARGE_LIMIT, $urandom());
    send_request(OP_ALLOC, 32'hFFFF_FFFF, $urandom());
    send_request(OP_ALLOC, 32'h8000_0000, $urandom());
    // large free wins over a foreign address and floors the counter
    send_request(OP_FREE, 32'hFFFF_FFFF, 32'hFFFF_0000);
    // null free is flagged even though the base is zero
    send_request(OP_FREE, 32'd8, 32'h0);
    // first address past the arena, and the top of the address space
    send_request(OP_FREE, 32'd8, ARENA_BYTES);
    send_request(OP_FREE, 32'd8, 32'hFFFF_FFFF);
    // unaligned free of the last granule, then the same granule again
    send_request(OP_FREE, 32'd24, ARENA_BYTES - 1);
    send_request(OP_FREE, 32'd24, ARENA_BYTES - 8);
    // both pops land on the doubly freed granule
    send_request(OP_ALLOC, 32'd17, $urandom());
    send_request(OP_ALLOC, 32'd24, $urandom());
    // power of two classes through the lists
    send_request(OP_FREE, 32'd1024, 32'h0000_0200);
    send_request(OP_FREE, 32'd1025, 32'h0000_2000);
    send_request(OP_ALLOC, 32'd2048, $urandom());
    send_request(OP_ALLOC, 32'd1000, $urandom());
    // wrong size free of a live block
    send_request(OP_FREE, 32'd40, 32'h0000_0008);
    quiesce();

    // top of the address space, arena addresses wrap through zero
    set_arena_base(32'hFFFF_FFFF);
    random_traffic(200, 1'b0);
    quiesce();

    // arbitrary base; the long receiver hold-off falls in this phase
    set_arena_base($urandom());
    random_traffic(250, 1'b0);
    quiesce();

    set_arena_base('0);
    random_traffic(200, 1'b0);
    quiesce();

    // arena straddles the wrap point, and big blocks run the bump pointer out
    set_arena_base(32'hFFFF_8000);
    random_traffic(180, 1'b1);
    quiesce();

    $display("covered %0d requests (%0d alloc, %0d free) over %0d arena bases, %0d checked",
             alloc_sent + free_sent, alloc_sent, free_sent, bases_used, sb.matched);
    $display("status mix: ok %0d, large %0d, exhausted %0d, null %0d, foreign %0d; pops %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_LARGE], sb.status_seen[ST_EXHAUSTED],
             sb.status_seen[ST_NULL_FREE], sb.status_seen[ST_FOREIGN], sb.pops);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
